[src/ubd_pkg.sv]
package ubd_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEFT_W      = 3;
    localparam int CP_W        = 21;
    localparam int PART_W      = 15;
    localparam int PEND_W      = 2;
    localparam int CONT_DATA_W = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEFT_W-1:0] LEFT_MAX = 3'd4;

    // Byte classes as seen by the front end
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_LEAD2 = 3'd1,
        CLS_LEAD3 = 3'd2,
        CLS_LEAD4 = 3'd3,
        CLS_CONT  = 3'd4,
        CLS_BAD   = 3'd5
    } ubd_cls_t;

    // One classified request on its way to the back end
    typedef struct packed {
        ubd_cls_t          cls;
        logic [BYTE_W-1:0] data;
        logic              trunc;    // lead would run past the buffer end
        logic              no_byte;  // bytes_left was zero
    } ubd_req_t;

    // Handshake between queue and back end
    typedef struct packed {
        logic     valid;
        ubd_req_t req;
    } ubd_issue_t;

endpackage

[src/ubd_byte_if.sv]
interface ubd_byte_if;
    import ubd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic [LEFT_W-1:0] bytes_left;

    modport source (output valid, output data_byte, output bytes_left, input ready);
    modport sink   (input valid, input data_byte, input bytes_left, output ready);
endinterface

[src/ubd_char_if.sv]
interface ubd_char_if;
    import ubd_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            decode_error;

    modport source (output valid, output code_point, output decode_error, input ready);
    modport sink   (input valid, input code_point, input decode_error, output ready);
endinterface

[src/ubd_front.sv]
module ubd_front (
    ubd_byte_if.sink          byte_stream,
    input  logic              queue_ready,
    output logic              push_valid,
    output ubd_pkg::ubd_req_t push_req
);
    import ubd_pkg::*;

    logic [BYTE_W-1:0] b;
    logic [LEFT_W-1:0] left_sat;
    logic [PEND_W-1:0] need;
    ubd_cls_t          cls;

    assign b = byte_stream.data_byte;

    // clamp to four
    assign left_sat = (byte_stream.bytes_left > LEFT_MAX) ? LEFT_MAX : byte_stream.bytes_left;

    always_comb
    begin
        need = '0;
        if (b[7] == 1'b0)
        begin
            cls = CLS_ASCII;
        end
        else if (b[7:5] == 3'b110)
        begin
            cls  = CLS_LEAD2;
            need = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            cls  = CLS_LEAD3;
            need = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            cls  = CLS_LEAD4;
            need = 2'd3;
        end
        else if (b[7:6] == 2'b10)
        begin
            cls = CLS_CONT;
        end
        else
        begin
            cls = CLS_BAD;
        end
    end

    assign push_req.cls     = cls;
    assign push_req.data    = b;
    assign push_req.trunc   = ({1'b0, need} >= left_sat) && (need != '0);
    assign push_req.no_byte = (byte_stream.bytes_left == '0);

    assign push_valid        = byte_stream.valid;
    assign byte_stream.ready = queue_ready;
endmodule

[src/ubd_queue.sv]
module ubd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  ubd_pkg::ubd_req_t   push_req,
    output logic                push_ready,
    output ubd_pkg::ubd_issue_t issue,
    input  logic                issue_ready
);
    import ubd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ubd_req_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;

    assign push_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push        = push_valid && push_ready;
    assign issue.valid = (count_reg != '0);
    assign issue.req   = slot_reg[rd_ptr_reg];
    assign pop         = issue.valid && issue_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end
endmodule

[src/ubd_back.sv]
module ubd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ubd_pkg::ubd_issue_t issue,
    output logic                issue_ready,
    ubd_char_if.source          char_stream
);
    import ubd_pkg::*;

    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [PART_W-1:0] partial_reg, partial_next;
    logic              out_valid_reg;
    logic [CP_W-1:0]   cp_reg;
    logic              err_reg;

    logic              take;
    logic              emit;
    logic [CP_W-1:0]   emit_cp;
    logic              emit_err;
    logic [CP_W-1:0]   shifted;
    ubd_req_t          req;

    assign req         = issue.req;
    assign issue_ready = !out_valid_reg || char_stream.ready;
    assign take        = issue.valid && issue_ready;
    assign shifted     = {partial_reg, req.data[CONT_DATA_W-1:0]};

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        emit         = 1'b0;
        emit_cp      = '0;
        emit_err     = 1'b0;
        if (pending_reg != '0)
        begin
            if (req.cls != CLS_CONT)
            begin
                // drop the open sequence and flag a decode error
                pending_next = '0;
                partial_next = '0;
                emit         = 1'b1;
                emit_err     = 1'b1;
            end
            else if (pending_reg == 2'd1)
            begin
                pending_next = '0;
                partial_next = '0;
                emit         = 1'b1;
                emit_cp      = shifted;
            end
            else
            begin
                pending_next = pending_reg - 2'd1;
                partial_next = shifted[PART_W-1:0];
            end
        end
        else if (!req.no_byte)
        begin
            unique case (req.cls) inside
                CLS_ASCII:
                begin
                    emit    = 1'b1;
                    emit_cp = CP_W'(req.data);
                end
                CLS_LEAD2, CLS_LEAD3, CLS_LEAD4:
                begin
                    if (req.trunc)
                    begin
                        emit     = 1'b1;
                        emit_err = 1'b1;
                    end
                    else if (req.cls == CLS_LEAD2)
                    begin
                        pending_next = 2'd1;
                        partial_next = PART_W'(req.data[4:0]);
                    end
                    else if (req.cls == CLS_LEAD3)
                    begin
                        pending_next = 2'd2;
                        partial_next = PART_W'(req.data[3:0]);
                    end
                    else
                    begin
                        pending_next = 2'd3;
                        partial_next = PART_W'(req.data[2:0]);
                    end
                end
                default:
                begin
                    emit     = 1'b1;
                    emit_err = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            partial_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
            end
            if (take && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (char_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            cp_reg  <= emit_cp;
            err_reg <= emit_err;
        end
    end

    assign char_stream.valid        = out_valid_reg;
    assign char_stream.code_point   = cp_reg;
    assign char_stream.decode_error = err_reg;
endmodule

[src/utf8_byte_decoder.sv]
// Channel       Dir   Payload                          Request moves
// byte_stream   in    data_byte[7:0], bytes_left[2:0]  one buffer byte
// char_stream   out   code_point[20:0], decode_error   zero or one character
//
// One byte per cycle sustained while the output is not stalled. A byte is
// classified on acceptance and parked in a two-entry queue; the back end
// retires one queued request per cycle, and each result passes a queue slot,
// then the output register. The rate is set by the sequence update in the
// back end. Reset (rst_n low, asynchronous) empties the queue, closes any
// open sequence and clears the output valid. A stalled output holds the back
// end; the queue keeps taking bytes until both entries are full.
module utf8_byte_decoder (
    input  logic       clk,
    input  logic       rst_n,
    ubd_byte_if.sink   byte_stream,
    ubd_char_if.source char_stream
);
    import ubd_pkg::*;

    logic       push_valid;
    logic       push_ready;
    ubd_req_t   push_req;
    ubd_issue_t issue;
    logic       issue_ready;

    // classify each request as it arrives
    ubd_front u_front (
        .byte_stream (byte_stream),
        .queue_ready (push_ready),
        .push_valid  (push_valid),
        .push_req    (push_req)
    );

    // decouple acceptance from the sequence tracker
    ubd_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_req    (push_req),
        .push_ready  (push_ready),
        .issue       (issue),
        .issue_ready (issue_ready)
    );

    // advance the open sequence and drive the result register
    ubd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .issue_ready (issue_ready),
        .char_stream (char_stream)
    );
endmodule
